// ----- rtl/vopf_pkg.sv -----
// ----------------------------------------------------------------------------
// vopf_pkg
// Shared types and constants of the voxel occupancy point filter.
// ----------------------------------------------------------------------------
package vopf_pkg;

  // Default grid geometry and counter size
  localparam int VOXELS_X_DEF   = 64;
  localparam int VOXELS_Y_DEF   = 64;
  localparam int VOXELS_Z_DEF   = 32;
  localparam int VOXEL_MM_DEF   = 100;
  localparam int COUNT_BITS_DEF = 8;

  // Coordinate and register widths
  localparam int COORD_W = 16;
  localparam int THR_W   = 8;

  // Front pipeline length and decoupling queue depth (power of two)
  localparam int FE_STAGES = 5;
  localparam int FE_CNT_W  = $clog2(FE_STAGES + 1);
  localparam int QDEPTH    = 16;
  localparam int QCNT_W    = $clog2(QDEPTH + 1);

  // Frame tag stored next to each counter
  localparam int EPOCH_BITS = 4;

  // Configuration register indexes
  localparam int CFG_IDX_W = 3;
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SENSOR_X      = 3'd0,
    CFG_SENSOR_Y      = 3'd1,
    CFG_SENSOR_Z      = 3'd2,
    CFG_GROUND_HEIGHT = 3'd3,
    CFG_ROOF_HEIGHT   = 3'd4,
    CFG_MAX_RANGE     = 3'd5,
    CFG_OCC_THRESHOLD = 3'd6
  } cfg_reg_e;

  // Back end state
  typedef enum logic {
    BK_SWEEP = 1'b0,
    BK_RUN   = 1'b1
  } bk_state_e;

  typedef struct packed {
    logic signed [COORD_W-1:0] sensor_x;
    logic signed [COORD_W-1:0] sensor_y;
    logic signed [COORD_W-1:0] sensor_z;
    logic signed [COORD_W-1:0] ground_height;
    logic signed [COORD_W-1:0] roof_height;
    logic        [COORD_W-1:0] max_range;
    logic        [THR_W-1:0]   occ_threshold;
  } cfg_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
    logic signed [COORD_W-1:0] z;
    logic        [COORD_W-1:0] depth;
  } point_t;

  // Control bits of one queue entry
  typedef struct packed {
    logic clear;    // new frame command
    logic roof_ok;  // point at or below roof height
  } q_ctl_t;

endpackage

// ----- rtl/vopf_axis.sv -----
// ----------------------------------------------------------------------------
// vopf_axis
// Two-stage voxel index unit for one axis: box test, then divide by the
// doubled voxel size through a reciprocal multiply.
// ----------------------------------------------------------------------------
module vopf_axis #(
  parameter  int NVOX     = vopf_pkg::VOXELS_X_DEF,
  parameter  int VOXEL_MM = vopf_pkg::VOXEL_MM_DEF,
  localparam int IW       = $clog2(NVOX)
) (
  input  logic                                clk_i,
  input  logic signed [vopf_pkg::COORD_W-1:0] p_i,
  input  logic signed [vopf_pkg::COORD_W-1:0] c_i,
  output logic        [IW-1:0]                idx_o,
  output logic                                ok_o
);

  localparam int SPAN     = NVOX * VOXEL_MM;
  localparam int TWO_SPAN = 2 * SPAN;
  localparam int DIV      = 2 * VOXEL_MM;
  localparam int RW       = $clog2(SPAN + 131072) + 2;
  localparam int NW       = $clog2(TWO_SPAN);
  localparam int SH       = NW + $clog2(DIV);
  localparam int MW       = NW + 2;
  localparam int PW       = NW + MW;
  localparam logic [63:0] MUL64 = ((64'd1 << SH) + 64'(DIV) - 64'd1) / 64'(DIV);
  localparam logic [MW-1:0] MUL = MUL64[MW-1:0];

  logic signed [RW-1:0] diff;
  logic signed [RW-1:0] rel2;
  logic                 in_box;
  logic [NW-1:0]        rel_q;
  logic                 ok_a_q;
  logic [PW-1:0]        prod;

  // Doubled offset from the box's lower face; inside when 0 <= rel2 < 2*span
  always_comb begin
    diff   = RW'(p_i) - RW'(c_i);
    rel2   = (diff <<< 1) + RW'(SPAN);
    in_box = !rel2[RW-1] && (rel2 < RW'(TWO_SPAN));
  end

  always_ff @(posedge clk_i) begin
    rel_q  <= rel2[NW-1:0];
    ok_a_q <= in_box;
  end

  // floor(rel / DIV) as (rel * ceil(2^SH / DIV)) >> SH, exact over NW bits
  assign prod = PW'(rel_q) * PW'(MUL);

  always_ff @(posedge clk_i) begin
    idx_o <= prod[SH +: IW];
    ok_o  <= ok_a_q;
  end

endmodule

// ----- rtl/vopf_front.sv -----
// ----------------------------------------------------------------------------
// vopf_front
// Front pipeline: classifies each transaction, drops points outside the
// filter volume and forms the linear voxel address.
// ----------------------------------------------------------------------------
module vopf_front #(
  parameter  int VOXELS_X = vopf_pkg::VOXELS_X_DEF,
  parameter  int VOXELS_Y = vopf_pkg::VOXELS_Y_DEF,
  parameter  int VOXELS_Z = vopf_pkg::VOXELS_Z_DEF,
  parameter  int VOXEL_MM = vopf_pkg::VOXEL_MM_DEF,
  localparam int AW       = $clog2(VOXELS_X * VOXELS_Y * VOXELS_Z)
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            acc_i,
  input  logic                            command_i,
  input  vopf_pkg::point_t                point_i,
  input  vopf_pkg::cfg_t                  cfg_i,
  output logic                            push_o,
  output vopf_pkg::q_ctl_t                push_ctl_o,
  output logic [AW-1:0]                   push_addr_o,
  output vopf_pkg::point_t                push_point_o,
  output logic [vopf_pkg::FE_CNT_W-1:0]   count_o
);

  localparam int XW  = $clog2(VOXELS_X);
  localparam int YW  = $clog2(VOXELS_Y);
  localparam int ZW  = $clog2(VOXELS_Z);
  localparam int XYW = $clog2(VOXELS_X * VOXELS_Y);

  logic [vopf_pkg::FE_STAGES-1:0] vld_q;

  vopf_pkg::point_t pt1_q, pt2_q, pt3_q, pt4_q, pt5_q;
  logic cmd1_q, cmd2_q, cmd3_q, cmd4_q, cmd5_q;
  logic gate2_q, gate3_q, keep4_q, keep5_q;
  logic roof2_q, roof3_q, roof4_q, roof5_q;
  logic [XW-1:0]  ix;
  logic [YW-1:0]  iy;
  logic [ZW-1:0]  iz, iz4_q;
  logic           okx, oky, okz;
  logic [XYW-1:0] xy4_q;
  logic [AW-1:0]  addr5_q;

  // Stage valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[vopf_pkg::FE_STAGES-2:0], acc_i};
    end
  end

  // Per-axis index units, results aligned with stage 3
  vopf_axis #(.NVOX(VOXELS_X), .VOXEL_MM(VOXEL_MM)) u_axis_x (
    .clk_i, .p_i(pt1_q.x), .c_i(cfg_i.sensor_x), .idx_o(ix), .ok_o(okx)
  );
  vopf_axis #(.NVOX(VOXELS_Y), .VOXEL_MM(VOXEL_MM)) u_axis_y (
    .clk_i, .p_i(pt1_q.y), .c_i(cfg_i.sensor_y), .idx_o(iy), .ok_o(oky)
  );
  vopf_axis #(.NVOX(VOXELS_Z), .VOXEL_MM(VOXEL_MM)) u_axis_z (
    .clk_i, .p_i(pt1_q.z), .c_i(cfg_i.sensor_z), .idx_o(iz), .ok_o(okz)
  );

  // Payload pipeline
  always_ff @(posedge clk_i) begin
    // stage 1: capture
    cmd1_q  <= command_i;
    pt1_q   <= point_i;
    // stage 2: ground, range and roof tests
    cmd2_q  <= cmd1_q;
    pt2_q   <= pt1_q;
    gate2_q <= (pt1_q.z >= cfg_i.ground_height) && (pt1_q.depth <= cfg_i.max_range);
    roof2_q <= (pt1_q.z <= cfg_i.roof_height);
    // stage 3
    cmd3_q  <= cmd2_q;
    pt3_q   <= pt2_q;
    gate3_q <= gate2_q;
    roof3_q <= roof2_q;
    // stage 4: x/y part of the address
    cmd4_q  <= cmd3_q;
    pt4_q   <= pt3_q;
    keep4_q <= gate3_q && okx && oky && okz;
    roof4_q <= roof3_q;
    xy4_q   <= XYW'(ix * VOXELS_Y) + XYW'(iy);
    iz4_q   <= iz;
    // stage 5: full address
    cmd5_q  <= cmd4_q;
    pt5_q   <= pt4_q;
    keep5_q <= keep4_q;
    roof5_q <= roof4_q;
    addr5_q <= AW'(xy4_q * VOXELS_Z) + AW'(iz4_q);
  end

  // Only commands and points that pass the ground and range tests and lie inside the grid go to the queue
  assign push_o             = vld_q[vopf_pkg::FE_STAGES-1] && (cmd5_q || keep5_q);
  assign push_ctl_o.clear   = cmd5_q;
  assign push_ctl_o.roof_ok = roof5_q;
  assign push_addr_o        = addr5_q;
  assign push_point_o       = pt5_q;
  assign count_o            = vopf_pkg::FE_CNT_W'($countones(vld_q));

endmodule

// ----- rtl/vopf_queue.sv -----
// ----------------------------------------------------------------------------
// vopf_queue
// Small FIFO between the front pipeline and the counter back end.
// ----------------------------------------------------------------------------
module vopf_queue #(
  parameter int AW = 17
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          push_i,
  input  vopf_pkg::q_ctl_t              push_ctl_i,
  input  logic [AW-1:0]                 push_addr_i,
  input  vopf_pkg::point_t              push_point_i,
  input  logic                          pop_i,
  output vopf_pkg::q_ctl_t              head_ctl_o,
  output logic [AW-1:0]                 head_addr_o,
  output vopf_pkg::point_t              head_point_o,
  output logic                          empty_o,
  output logic [vopf_pkg::QCNT_W-1:0]   count_o
);

  localparam int PW = $clog2(vopf_pkg::QDEPTH);

  vopf_pkg::q_ctl_t ctl_q   [vopf_pkg::QDEPTH];
  logic [AW-1:0]    addr_q  [vopf_pkg::QDEPTH];
  vopf_pkg::point_t point_q [vopf_pkg::QDEPTH];

  logic [PW-1:0]                wr_ptr_q, rd_ptr_q;
  logic [vopf_pkg::QCNT_W-1:0]  cnt_q;

  // Pointers and fill level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) wr_ptr_q <= wr_ptr_q + 1'b1;
      if (pop_i)  rd_ptr_q <= rd_ptr_q + 1'b1;
      if (push_i && !pop_i)      cnt_q <= cnt_q + 1'b1;
      else if (pop_i && !push_i) cnt_q <= cnt_q - 1'b1;
    end
  end

  // Entry storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      ctl_q[wr_ptr_q]   <= push_ctl_i;
      addr_q[wr_ptr_q]  <= push_addr_i;
      point_q[wr_ptr_q] <= push_point_i;
    end
  end

  assign head_ctl_o   = ctl_q[rd_ptr_q];
  assign head_addr_o  = addr_q[rd_ptr_q];
  assign head_point_o = point_q[rd_ptr_q];
  assign empty_o      = (cnt_q == '0);
  assign count_o      = cnt_q;

endmodule

// ----- rtl/vopf_back.sv -----
// ----------------------------------------------------------------------------
// vopf_back
// Back end: voxel counter memory with read-modify-write, frame tags for
// clear commands, clearing sweep, and the output register.
// ----------------------------------------------------------------------------
module vopf_back #(
  parameter  int TOTAL      = vopf_pkg::VOXELS_X_DEF * vopf_pkg::VOXELS_Y_DEF *
                              vopf_pkg::VOXELS_Z_DEF,
  parameter  int COUNT_BITS = vopf_pkg::COUNT_BITS_DEF,
  localparam int AW         = $clog2(TOTAL)
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          q_empty_i,
  input  vopf_pkg::q_ctl_t              head_ctl_i,
  input  logic [AW-1:0]                 head_addr_i,
  input  vopf_pkg::point_t              head_point_i,
  output logic                          pop_o,
  input  logic [vopf_pkg::THR_W-1:0]    occ_threshold_i,
  input  logic                          out_stall_i,
  output logic                          out_valid_o,
  output vopf_pkg::point_t              out_point_o
);

  localparam int EB   = vopf_pkg::EPOCH_BITS;
  localparam int MEMW = EB + COUNT_BITS;
  localparam int CMPW = (COUNT_BITS > vopf_pkg::THR_W) ? COUNT_BITS : vopf_pkg::THR_W;

  vopf_pkg::bk_state_e state_q, state_d;

  logic [MEMW-1:0]       mem_q [TOTAL];
  logic [MEMW-1:0]       rd_q;
  logic [AW-1:0]         swp_addr_q;
  logic [EB-1:0]         epoch_q;

  logic                  b2_v_q;
  logic [AW-1:0]         b2_addr_q;
  vopf_pkg::point_t      b2_pt_q;
  logic                  b2_roof_q;
  logic                  fwd_hit_q;
  logic [COUNT_BITS-1:0] fwd_cnt_q;

  logic                  out_valid_q;
  vopf_pkg::point_t      out_pt_q;

  logic                  sweeping, swp_done;
  logic                  adv, b2_move, pop, point_pop, clear_pop, wrap;
  logic [EB-1:0]         rd_ep;
  logic [COUNT_BITS-1:0] rd_cnt, old_cnt, new_cnt;
  logic                  sat, emit;
  logic                  we;
  logic [AW-1:0]         waddr;
  logic [MEMW-1:0]       wdata;

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      vopf_pkg::BK_SWEEP: if (swp_done) state_d = vopf_pkg::BK_RUN;
      vopf_pkg::BK_RUN:   if (clear_pop && wrap) state_d = vopf_pkg::BK_SWEEP;
      default:            state_d = vopf_pkg::BK_SWEEP;
    endcase
  end

  // State outputs
  always_comb begin
    sweeping = 1'b0;
    unique case (state_q)
      vopf_pkg::BK_SWEEP: sweeping = 1'b1;
      vopf_pkg::BK_RUN:   sweeping = 1'b0;
      default:            sweeping = 1'b1;
    endcase
  end

  // Handshake between queue, counter stage and output register
  always_comb begin
    swp_done  = (swp_addr_q == AW'(TOTAL - 1));
    wrap      = (epoch_q == {EB{1'b1}});
    adv       = !out_valid_q || !out_stall_i;
    b2_move   = b2_v_q && adv;
    pop       = !q_empty_i && !sweeping && (!b2_v_q || adv);
    point_pop = pop && !head_ctl_i.clear;
    clear_pop = pop && head_ctl_i.clear;
  end

  // Counter update; a tag from an older frame reads as zero
  always_comb begin
    rd_ep   = rd_q[MEMW-1 -: EB];
    rd_cnt  = rd_q[COUNT_BITS-1:0];
    old_cnt = fwd_hit_q ? fwd_cnt_q : ((rd_ep == epoch_q) ? rd_cnt : '0);
    sat     = (old_cnt == {COUNT_BITS{1'b1}});
    new_cnt = sat ? old_cnt : old_cnt + COUNT_BITS'(1);
    emit    = !sat && (CMPW'(new_cnt) == CMPW'(occ_threshold_i)) && b2_roof_q;
    we      = sweeping || b2_move;
    waddr   = sweeping ? swp_addr_q : b2_addr_q;
    wdata   = sweeping ? '0 : {epoch_q, new_cnt};
  end

  // Counter memory, read data registered
  always_ff @(posedge clk_i) begin
    if (we)        mem_q[waddr] <= wdata;
    if (point_pop) rd_q <= mem_q[head_addr_i];
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= vopf_pkg::BK_SWEEP;
      swp_addr_q  <= '0;
      epoch_q     <= '0;
      b2_v_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (sweeping) swp_addr_q <= swp_done ? '0 : swp_addr_q + 1'b1;
      if (clear_pop) epoch_q <= wrap ? '0 : epoch_q + 1'b1;
      if (point_pop)    b2_v_q <= 1'b1;
      else if (b2_move) b2_v_q <= 1'b0;
      if (adv) out_valid_q <= b2_v_q && emit;
    end
  end

  // Payload registers; forward the write that lands with this item's read
  always_ff @(posedge clk_i) begin
    if (point_pop) begin
      b2_addr_q <= head_addr_i;
      b2_pt_q   <= head_point_i;
      b2_roof_q <= head_ctl_i.roof_ok;
      fwd_hit_q <= b2_move && (b2_addr_q == head_addr_i);
      fwd_cnt_q <= new_cnt;
    end
    if (adv && b2_v_q && emit) out_pt_q <= b2_pt_q;
  end

  assign pop_o       = pop;
  assign out_valid_o = out_valid_q;
  assign out_point_o = out_pt_q;

endmodule

// ----- rtl/voxel_occupancy_point_filter.sv -----
// ----------------------------------------------------------------------------
// voxel_occupancy_point_filter
// Counts points per voxel around the sensor and passes a point on when its
// voxel first reaches the occupancy threshold and the point lies at or below the roof height.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i / in_stall_o) carries one point or a clear
//   command per transaction; a clear starts a new frame. Output channel
//   (out_valid_o / out_stall_i) carries at most one point per input.
//   Configuration is written through cfg_valid_i / cfg_ready_o with
//   cfg_index_i selecting the register; cfg_ready_o is always high.
// Throughput: one transaction per cycle unless an output stall or a sweep
//   holds the back end, set by the single read-modify-write port of the
//   counter memory (back-to-back hits on one voxel forward).
// Path to out_valid_o: 5 front stages, the queue, memory read, output register.
// Reset: all counters are cleared by a sweep over VOXELS_X*VOXELS_Y*VOXELS_Z
//   addresses (131072 at defaults); the queue fills and in_stall_o rises while
//   it runs. Clear commands retag the frame; every sixteenth clear runs the
//   same sweep.
// Stall: a held output stops the back end; the queue keeps absorbing input
//   until it and the front pipeline hold 16 transactions, then in_stall_o.
// ----------------------------------------------------------------------------
module voxel_occupancy_point_filter #(
  parameter int VOXELS_X   = vopf_pkg::VOXELS_X_DEF,
  parameter int VOXELS_Y   = vopf_pkg::VOXELS_Y_DEF,
  parameter int VOXELS_Z   = vopf_pkg::VOXELS_Z_DEF,
  parameter int VOXEL_MM   = vopf_pkg::VOXEL_MM_DEF,
  parameter int COUNT_BITS = vopf_pkg::COUNT_BITS_DEF
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  // input channel
  input  logic                                 in_valid_i,
  output logic                                 in_stall_o,
  input  logic                                 command_i,
  input  logic signed [vopf_pkg::COORD_W-1:0]  point_x_i,
  input  logic signed [vopf_pkg::COORD_W-1:0]  point_y_i,
  input  logic signed [vopf_pkg::COORD_W-1:0]  point_z_i,
  input  logic        [vopf_pkg::COORD_W-1:0]  depth_mm_i,
  // output channel
  output logic                                 out_valid_o,
  input  logic                                 out_stall_i,
  output logic signed [vopf_pkg::COORD_W-1:0]  out_x_o,
  output logic signed [vopf_pkg::COORD_W-1:0]  out_y_o,
  output logic signed [vopf_pkg::COORD_W-1:0]  out_z_o,
  output logic        [vopf_pkg::COORD_W-1:0]  out_depth_o,
  // configuration channel
  input  logic                                 cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  logic        [vopf_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic        [vopf_pkg::COORD_W-1:0]  cfg_data_i
);

  localparam int TOTAL = VOXELS_X * VOXELS_Y * VOXELS_Z;
  localparam int AW    = $clog2(TOTAL);
  localparam int OCC_W = $clog2(vopf_pkg::QDEPTH + vopf_pkg::FE_STAGES + 1);

  vopf_pkg::cfg_t   cfg_q;
  vopf_pkg::point_t in_pt, out_pt;
  vopf_pkg::q_ctl_t push_ctl, head_ctl;
  vopf_pkg::point_t push_pt, head_pt;

  logic                          acc;
  logic                          q_push, q_pop, q_empty;
  logic [AW-1:0]                 push_addr, head_addr;
  logic [vopf_pkg::FE_CNT_W-1:0] fe_cnt;
  logic [vopf_pkg::QCNT_W-1:0]   q_cnt;
  logic [OCC_W-1:0]              occ;

  // Configuration registers
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.sensor_x      <= '0;
      cfg_q.sensor_y      <= '0;
      cfg_q.sensor_z      <= '0;
      cfg_q.ground_height <= 16'sh8000;
      cfg_q.roof_height   <= 16'sh7FFF;
      cfg_q.max_range     <= 16'hFFFF;
      cfg_q.occ_threshold <= 8'd1;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (vopf_pkg::cfg_reg_e'(cfg_index_i))
        vopf_pkg::CFG_SENSOR_X:      cfg_q.sensor_x      <= cfg_data_i;
        vopf_pkg::CFG_SENSOR_Y:      cfg_q.sensor_y      <= cfg_data_i;
        vopf_pkg::CFG_SENSOR_Z:      cfg_q.sensor_z      <= cfg_data_i;
        vopf_pkg::CFG_GROUND_HEIGHT: cfg_q.ground_height <= cfg_data_i;
        vopf_pkg::CFG_ROOF_HEIGHT:   cfg_q.roof_height   <= cfg_data_i;
        vopf_pkg::CFG_MAX_RANGE:     cfg_q.max_range     <= cfg_data_i;
        vopf_pkg::CFG_OCC_THRESHOLD: cfg_q.occ_threshold <= cfg_data_i[vopf_pkg::THR_W-1:0];
        default: ;
      endcase
    end
  end

  // Input acceptance: front stages plus queue never exceed the queue depth
  assign occ        = OCC_W'(fe_cnt) + OCC_W'(q_cnt);
  assign in_stall_o = (occ >= OCC_W'(vopf_pkg::QDEPTH));
  assign acc        = in_valid_i && !in_stall_o;

  assign in_pt.x     = point_x_i;
  assign in_pt.y     = point_y_i;
  assign in_pt.z     = point_z_i;
  assign in_pt.depth = depth_mm_i;

  vopf_front #(
    .VOXELS_X(VOXELS_X), .VOXELS_Y(VOXELS_Y), .VOXELS_Z(VOXELS_Z), .VOXEL_MM(VOXEL_MM)
  ) u_front (
    .clk_i,
    .rst_ni,
    .acc_i        (acc),
    .command_i,
    .point_i      (in_pt),
    .cfg_i        (cfg_q),
    .push_o       (q_push),
    .push_ctl_o   (push_ctl),
    .push_addr_o  (push_addr),
    .push_point_o (push_pt),
    .count_o      (fe_cnt)
  );

  vopf_queue #(.AW(AW)) u_queue (
    .clk_i,
    .rst_ni,
    .push_i       (q_push),
    .push_ctl_i   (push_ctl),
    .push_addr_i  (push_addr),
    .push_point_i (push_pt),
    .pop_i        (q_pop),
    .head_ctl_o   (head_ctl),
    .head_addr_o  (head_addr),
    .head_point_o (head_pt),
    .empty_o      (q_empty),
    .count_o      (q_cnt)
  );

  vopf_back #(.TOTAL(TOTAL), .COUNT_BITS(COUNT_BITS)) u_back (
    .clk_i,
    .rst_ni,
    .q_empty_i       (q_empty),
    .head_ctl_i      (head_ctl),
    .head_addr_i     (head_addr),
    .head_point_i    (head_pt),
    .pop_o           (q_pop),
    .occ_threshold_i (cfg_q.occ_threshold),
    .out_stall_i,
    .out_valid_o,
    .out_point_o     (out_pt)
  );

  assign out_x_o     = out_pt.x;
  assign out_y_o     = out_pt.y;
  assign out_z_o     = out_pt.z;
  assign out_depth_o = out_pt.depth;

  // Credit accounting keeps the queue from overflowing
  a_occ_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    occ <= OCC_W'(vopf_pkg::QDEPTH))
    else $error("front plus queue occupancy above queue depth");

  a_no_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (q_push && !q_pop) |-> (q_cnt < vopf_pkg::QCNT_W'(vopf_pkg::QDEPTH)))
    else $error("push into full queue");

  a_accept_tracked: assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc |=> (fe_cnt != '0))
    else $error("accepted transaction missing from front pipeline");

  a_pop_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop |-> (q_cnt != '0))
    else $error("pop from empty queue");

endmodule
